FILE: sv/lsss_pkg.sv
// ----------------------------------------------------------------------------
// lsss_pkg: shared types and constants
// Period table, register codes and the per-item step bundle for the LED
// sweep speed selector.
// ----------------------------------------------------------------------------
`default_nettype none

package lsss_pkg;

	localparam int LED_COUNT_DEF   = 5;
	localparam int SPEED_COUNT_DEF = 7;

	localparam int DEBOUNCE_W = 10;
	localparam int LONG_W     = 12;
	localparam int SINCE_W    = 12;
	localparam int PERIOD_W   = 10;
	localparam int CFG_DATA_W = 12;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd50;
	localparam logic [LONG_W-1:0]     LONG_RST     = 12'd200;

	typedef enum logic {
		CFG_DEBOUNCE   = 1'b0,
		CFG_LONG_PRESS = 1'b1
	} cfg_index_t;

	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [3:0]          speed_idx_t;

	localparam int PERIOD_ENTRIES = 7;

	localparam period_t PERIOD_TABLE [PERIOD_ENTRIES] = '{
		10'd1000, 10'd500, 10'd400, 10'd300, 10'd200, 10'd100, 10'd50
	};

	typedef struct packed {
		logic en;
		logic level;
		logic tick;
	} step_t;

	function automatic period_t period_of(input speed_idx_t idx);
		period_t p;
		if (idx < speed_idx_t'(PERIOD_ENTRIES)) begin
			p = PERIOD_TABLE[idx[2:0]];
		end else begin
			p = PERIOD_TABLE[PERIOD_ENTRIES-1];
		end
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: sv/led_sweep_speed_selector_unit.sv
// ----------------------------------------------------------------------------
// led_sweep_speed_selector_unit: LED chaser with debounced speed button
// Data path: an input register, then a result register, between input accept
// and result valid. Throughput: one item per cycle unless out_stall holds the pipeline.
// Reset: asynchronous, clears the pipeline, button/sweep state and loads the
// register defaults (debounce 50 ms, long press 200 ms).
// ----------------------------------------------------------------------------
`default_nettype none

module led_sweep_speed_selector_unit #(
	parameter int LED_COUNT   = lsss_pkg::LED_COUNT_DEF,
	parameter int SPEED_COUNT = lsss_pkg::SPEED_COUNT_DEF,
	localparam int SW = $clog2(SPEED_COUNT + 1)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [lsss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            button_level,
	input  wire logic                            ms_elapsed,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [LED_COUNT-1:0]            led_pattern,
	output logic                                 paused,
	output logic      [SW-1:0]                   speed_index
);

	logic [lsss_pkg::DEBOUNCE_W-1:0] debounce_q;
	logic [lsss_pkg::LONG_W-1:0]     long_q;
	logic                            valid_s1;
	logic                            level_s1;
	logic                            tick_s1;
	logic                            advance;
	logic                            accept;
	lsss_pkg::step_t                 step;
	logic [SW-1:0]                   speed_next;
	logic [LED_COUNT-1:0]            pattern;
	logic                            out_valid_q;
	logic [LED_COUNT-1:0]            pattern_q;
	logic                            paused_q;
	logic [SW-1:0]                   speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= lsss_pkg::DEBOUNCE_RST;
			long_q     <= lsss_pkg::LONG_RST;
		end else if (cfg_we) begin
			case (lsss_pkg::cfg_index_t'(cfg_index))
				lsss_pkg::CFG_DEBOUNCE:   debounce_q <= cfg_data[lsss_pkg::DEBOUNCE_W-1:0];
				lsss_pkg::CFG_LONG_PRESS: long_q     <= cfg_data[lsss_pkg::LONG_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= button_level;
			tick_s1  <= ms_elapsed;
		end
	end

	assign step = '{en: valid_s1 && advance, level: level_s1, tick: tick_s1};

	lsss_button #(
		.SPEED_COUNT (SPEED_COUNT)
	) u_button (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.debounce_ms   (debounce_q),
		.long_press_ms (long_q),
		.speed_next    (speed_next)
	);

	lsss_sweep #(
		.LED_COUNT   (LED_COUNT),
		.SPEED_COUNT (SPEED_COUNT)
	) u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.speed_sel (speed_next),
		.pattern   (pattern)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step.en) begin
			pattern_q <= pattern;
			paused_q  <= speed_next >= SW'(SPEED_COUNT);
			speed_q   <= speed_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign led_pattern = pattern_q;
	assign paused      = paused_q;
	assign speed_index = speed_q;

endmodule

`default_nettype wire

FILE: sv/lsss_button.sv
// ----------------------------------------------------------------------------
// lsss_button: debounced button and speed index
// Detects press and release edges, times the press and steps or resets the
// speed index.
// ----------------------------------------------------------------------------
`default_nettype none

module lsss_button #(
	parameter int SPEED_COUNT = lsss_pkg::SPEED_COUNT_DEF,
	localparam int SW = $clog2(SPEED_COUNT + 1)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire lsss_pkg::step_t                 step,
	input  wire logic [lsss_pkg::DEBOUNCE_W-1:0] debounce_ms,
	input  wire logic [lsss_pkg::LONG_W-1:0]     long_press_ms,
	output logic      [SW-1:0]                   speed_next
);

	logic                         prev_q;
	logic                         pend_q;
	logic                         pend_d;
	logic [SW-1:0]                speed_q;
	logic [lsss_pkg::SINCE_W-1:0] since_q;
	logic [lsss_pkg::SINCE_W-1:0] since_mid;
	logic [lsss_pkg::SINCE_W-1:0] since_d;
	logic                         fall;
	logic                         rise;

	assign fall = prev_q & ~step.level;
	assign rise = ~prev_q & step.level;

	always_comb begin
		pend_d     = pend_q;
		speed_next = speed_q;
		since_mid  = since_q;
		if (fall) begin
			if (since_q >= lsss_pkg::SINCE_W'(debounce_ms)) begin
				pend_d    = 1'b1;
				since_mid = '0;
			end
		end else if (rise) begin
			if (pend_q) begin
				pend_d = 1'b0;
				if (since_q < long_press_ms) begin
					if (speed_q < SW'(SPEED_COUNT)) begin
						speed_next = speed_q + SW'(1);
					end
				end else begin
					speed_next = '0;
				end
				since_mid = '0;
			end
		end
		since_d = since_mid;
		if (step.tick && since_mid != '1) begin
			since_d = since_mid + lsss_pkg::SINCE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b1;
			pend_q  <= 1'b0;
			speed_q <= '0;
			since_q <= '0;
		end else if (step.en) begin
			prev_q  <= step.level;
			pend_q  <= pend_d;
			speed_q <= speed_next;
			since_q <= since_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/lsss_sweep.sv
// ----------------------------------------------------------------------------
// lsss_sweep: back-and-forth LED sweep
// Tracks the sweep position and the blink countdown and forms the LED drive.
// ----------------------------------------------------------------------------
`default_nettype none

module lsss_sweep #(
	parameter int LED_COUNT   = lsss_pkg::LED_COUNT_DEF,
	parameter int SPEED_COUNT = lsss_pkg::SPEED_COUNT_DEF,
	localparam int SW = $clog2(SPEED_COUNT + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lsss_pkg::step_t      step,
	input  wire logic [SW-1:0]        speed_sel,
	output logic      [LED_COUNT-1:0] pattern
);

	localparam int SWEEP_LEN = 2 * (LED_COUNT - 1);
	localparam int STEP_W    = $clog2(SWEEP_LEN);
	localparam int LED_W     = $clog2(LED_COUNT);

	logic [STEP_W-1:0]             step_q;
	logic [STEP_W-1:0]             step_d;
	logic                          active_q;
	logic                          active_d;
	lsss_pkg::period_t             remain_q;
	lsss_pkg::period_t             remain_d;
	logic [LED_W-1:0]              led;
	logic [STEP_W:0]               mirror;
	logic                          paused_now;
	logic                          blink_end;

	assign paused_now = speed_sel >= SW'(SPEED_COUNT);
	assign mirror     = (STEP_W + 1)'(SWEEP_LEN) - {1'b0, step_q};
	assign led        = ({1'b0, step_q} < (STEP_W + 1)'(LED_COUNT)) ?
		LED_W'(step_q) : LED_W'(mirror);

	always_comb begin
		step_d    = step_q;
		active_d  = active_q;
		remain_d  = remain_q;
		blink_end = 1'b0;
		if (!active_q) begin
			if (!paused_now) begin
				remain_d = lsss_pkg::period_of(lsss_pkg::speed_idx_t'(speed_sel));
				active_d = 1'b1;
			end
		end else if (step.tick) begin
			if (remain_q <= lsss_pkg::period_t'(1)) begin
				remain_d  = '0;
				active_d  = 1'b0;
				blink_end = 1'b1;
				step_d    = (step_q == STEP_W'(SWEEP_LEN - 1)) ? '0 : step_q + STEP_W'(1);
			end else begin
				remain_d = remain_q - lsss_pkg::period_t'(1);
			end
		end
		for (int i = 0; i < LED_COUNT; i++) begin
			pattern[i] = (led == LED_W'(i)) && !blink_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			active_q <= 1'b0;
			remain_q <= '0;
		end else if (step.en) begin
			step_q   <= step_d;
			active_q <= active_d;
			remain_q <= remain_d;
		end
	end

endmodule

`default_nettype wire

FILE: dv/tb_led_sweep_speed_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_sweep_speed_selector_unit: LED chaser with debounced speed button
// Drives button samples and millisecond ticks with random gaps on both sides.
// It predicts the LED pattern, pause flag and speed index of every item and
// checks each result in order. Directed cases are followed by random
// press/hold/release sequences under several register settings.
// ----------------------------------------------------------------------------

module tb_led_sweep_speed_selector_unit;

	localparam int LEDS        = 5;
	localparam int SPEEDS      = 7;
	localparam int SWEEP_LEN   = 2 * (LEDS - 1);
	localparam int SINCE_SAT   = 4095;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [LEDS-1:0] pattern;
		logic            paused;
		logic [2:0]      speed;
	} sweep_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic                            cfg_index;
	logic [lsss_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_stall;
	logic                            button_level;
	logic                            ms_elapsed;
	logic                            out_valid;
	logic                            out_stall;
	logic [LEDS-1:0]                 led_pattern;
	logic                            paused;
	logic [2:0]                      speed_index;

	sweep_result_t sweep_results_q[$];
	int            mismatch_count = 0;
	int            items_sent     = 0;
	int            stall_watch    = 0;
	bit            tx_idle_en     = 1'b1;
	bit            rx_idle_en     = 1'b1;
	int            rx_hold_req    = 0;

	int   deb_ms;
	int   long_ms;
	logic prev_btn;
	int   since_ms;
	logic press_wait;
	int   spd;
	int   sweep_pos;
	logic blink_on;
	int   blink_left;

	led_sweep_speed_selector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.ms_elapsed   (ms_elapsed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.led_pattern  (led_pattern),
		.paused       (paused),
		.speed_index  (speed_index)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic sweep_result_t predict_sweep(input logic level, input logic tick);
		sweep_result_t   r;
		int              led;
		logic [LEDS-1:0] pat;
		if (prev_btn && !level) begin
			if (since_ms >= deb_ms) begin
				press_wait = 1'b1;
				since_ms   = 0;
			end
		end else if (!prev_btn && level) begin
			if (press_wait) begin
				press_wait = 1'b0;
				if (since_ms < long_ms) begin
					if (spd < SPEEDS) spd++;
				end else begin
					spd = 0;
				end
				since_ms = 0;
			end
		end
		prev_btn = level;

		if (sweep_pos >= SWEEP_LEN) sweep_pos = 0;
		led = (sweep_pos < LEDS) ? sweep_pos : SWEEP_LEN - sweep_pos;
		pat = LEDS'(1 << led);
		if (!blink_on) begin
			if (spd < SPEEDS) begin
				blink_left = int'(lsss_pkg::PERIOD_TABLE[(spd < lsss_pkg::PERIOD_ENTRIES) ?
					spd : lsss_pkg::PERIOD_ENTRIES - 1]);
				blink_on   = 1'b1;
			end
		end else if (tick) begin
			if (blink_left <= 1) begin
				blink_left = 0;
				blink_on   = 1'b0;
				sweep_pos  = (sweep_pos + 1 >= SWEEP_LEN) ? 0 : sweep_pos + 1;
				pat        = '0;
			end else begin
				blink_left--;
			end
		end

		if (tick && since_ms < SINCE_SAT) since_ms++;

		r.pattern = pat;
		r.paused  = (spd >= SPEEDS);
		r.speed   = 3'(spd);
		return r;
	endfunction

	task automatic send_item(input logic level, input logic tick);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		button_level <= level;
		ms_elapsed   <= tick;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sweep_results_q.push_back(predict_sweep(level, tick));
		items_sent++;
	endtask

	task automatic send_run(input logic level, input int count, input int tick_pct);
		repeat (count) send_item(level, $urandom_range(0, 99) < tick_pct);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sweep_results_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input lsss_pkg::cfg_index_t idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= lsss_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lsss_pkg::CFG_DEBOUNCE:   deb_ms  = value & 10'h3FF;
			lsss_pkg::CFG_LONG_PRESS: long_ms = value & 12'hFFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_debounce_and_release();
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b1);
		send_item(1'b1, 1'b0);
		wait_drained();
		write_reg(lsss_pkg::CFG_DEBOUNCE, 0);
		write_reg(lsss_pkg::CFG_LONG_PRESS, 3);
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b0);
		send_run(1'b0, 3, 100);
		send_item(1'b1, 1'b0);
		wait_drained();
	endtask

	task automatic test_speed_steps_to_pause();
		write_reg(lsss_pkg::CFG_DEBOUNCE, 0);
		write_reg(lsss_pkg::CFG_LONG_PRESS, 4095);
		repeat (SPEEDS + 1) begin
			send_item(1'b0, 1'b0);
			send_item(1'b1, 1'b1);
		end
		wait_drained();
		write_reg(lsss_pkg::CFG_LONG_PRESS, 0);
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b0);
		wait_drained();
	endtask

	task automatic test_long_press_boundary();
		write_reg(lsss_pkg::CFG_DEBOUNCE, 0);
		write_reg(lsss_pkg::CFG_LONG_PRESS, 20);
		send_item(1'b0, 1'b0);
		send_run(1'b0, 19, 100);
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b0);
		send_run(1'b0, 20, 100);
		send_item(1'b1, 1'b0);
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		write_reg(lsss_pkg::CFG_DEBOUNCE, 2);
		write_reg(lsss_pkg::CFG_LONG_PRESS, 12);
		tx_idle_en  = 1'b0;
		rx_hold_req = 60;
		repeat (4) begin
			send_run(1'b1, 4, 80);
			send_run(1'b0, $urandom_range(1, 16), 80);
		end
		tx_idle_en = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_sequences();
		int phase_start;
		int tick_pct;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(lsss_pkg::CFG_DEBOUNCE, $urandom_range(0, 8));
					write_reg(lsss_pkg::CFG_LONG_PRESS, $urandom_range(5, 40));
				end
				1: begin
					write_reg(lsss_pkg::CFG_DEBOUNCE, 0);
					write_reg(lsss_pkg::CFG_LONG_PRESS, 0);
				end
				2: begin
					write_reg(lsss_pkg::CFG_DEBOUNCE, 1023);
					write_reg(lsss_pkg::CFG_LONG_PRESS, 4095);
				end
				3: begin
					write_reg(lsss_pkg::CFG_DEBOUNCE, $urandom_range(0, 15));
					write_reg(lsss_pkg::CFG_LONG_PRESS, 4095);
				end
				4: begin
					write_reg(lsss_pkg::CFG_DEBOUNCE, 0);
					write_reg(lsss_pkg::CFG_LONG_PRESS, $urandom_range(1, 20));
				end
				default: begin
					write_reg(lsss_pkg::CFG_DEBOUNCE, $urandom_range(0, 10));
					write_reg(lsss_pkg::CFG_LONG_PRESS, $urandom_range(2, 30));
				end
			endcase
			tx_idle_en  = ($urandom_range(0, 3) != 0);
			rx_idle_en  = ($urandom_range(0, 3) != 0);
			tick_pct    = (phase == 3) ? 100 : $urandom_range(20, 95);
			phase_start = items_sent;
			while (items_sent - phase_start < 95) begin
				if ($urandom_range(0, 99) < 75) begin
					send_run(1'b1, $urandom_range(0, 12), tick_pct);
					send_run(1'b0, $urandom_range(1, 30), tick_pct);
				end else begin
					repeat ($urandom_range(1, 6))
						send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end
			wait_drained();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin : rx_proc
		int gap;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req > 0) begin
				gap         = rx_hold_req;
				rx_hold_req = 0;
			end else begin
				gap = rx_idle_en ? $urandom_range(0, 8) : 0;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		sweep_result_t seen;
		sweep_result_t want;
		if (out_valid && !out_stall) begin
			seen = '{led_pattern, paused, speed_index};
			if (sweep_results_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: led=%b paused=%b speed=%0d",
						seen.pattern, seen.paused, seen.speed);
			end else begin
				want = sweep_results_q.pop_front();
				if (seen !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected led=%b paused=%b speed=%0d, got led=%b paused=%b speed=%0d",
							want.pattern, want.paused, want.speed,
							seen.pattern, seen.paused, seen.speed);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stall_watch <= 0;
		end else if (stall_watch >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_watch <= stall_watch + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = lsss_pkg::CFG_DEBOUNCE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		button_level = 1'b1;
		ms_elapsed   = 1'b0;
		deb_ms       = int'(lsss_pkg::DEBOUNCE_RST);
		long_ms      = int'(lsss_pkg::LONG_RST);
		prev_btn     = 1'b1;
		since_ms     = 0;
		press_wait   = 1'b0;
		spd          = 0;
		sweep_pos    = 0;
		blink_on     = 1'b0;
		blink_left   = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_debounce_and_release();
		test_speed_steps_to_pause();
		test_long_press_boundary();
		test_output_backpressure();
		test_random_sequences();

		wait_drained();
		repeat (8) @(posedge clk);
		mismatch_count += sweep_results_q.size();
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
